// File: rtl/btk_pkg.sv
// ----------------------------------------------------------------------------
// btk_pkg: shared types and constants for the top-k distinct set
// Cell count, field widths, cell commands, neighbor link and control groups.
// ----------------------------------------------------------------------------
`default_nettype none

package btk_pkg;

  localparam int CAPACITY = 64;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int CAP_W    = 7;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_EVICT
  } btk_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } btk_state_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic signed [VALUE_W-1:0] val;
    logic                      lt;
    logic                      occ;
  } btk_link_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                      cmp_en;
    btk_op_t                   op;
    logic signed [VALUE_W-1:0] value;
  } btk_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/btk_cell.sv
// ----------------------------------------------------------------------------
// btk_cell: one slot of the sorted chain
// Holds one value, compares it against the broadcast value, and shifts
// toward or away from the head on insert and evict.
// ----------------------------------------------------------------------------
`default_nettype none

module btk_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire btk_pkg::btk_ctrl_t ctrl,
  input  wire btk_pkg::btk_link_t left,
  input  wire btk_pkg::btk_link_t right,
  output btk_pkg::btk_link_t      link,
  output logic                    eq
);
  import btk_pkg::*;

  logic signed [VALUE_W-1:0] val;
  logic signed [VALUE_W-1:0] val_next;
  logic                      lt;
  logic                      occ;

  assign link = '{val: val, lt: lt, occ: occ};

  always_comb begin
    val_next = val;
    case (ctrl.op)
      OP_INSERT: begin
        // cells above the insertion point move one slot away from the head
        if (!lt) begin
          if (left.lt) val_next = ctrl.value;
          else         val_next = left.val;
        end
      end
      OP_EVICT: begin
        // head drops out; cells below the insertion point move toward it
        if (right.lt)  val_next = right.val;
        else if (lt)   val_next = ctrl.value;
      end
      default: val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
      lt  <= 1'b0;
      eq  <= 1'b0;
    end else begin
      if (ctrl.cmp_en) begin
        lt <= occ && (val < ctrl.value);
        eq <= occ && (val == ctrl.value);
      end
      if (ctrl.op == OP_INSERT) occ <= occ | left.occ;
    end
  end

endmodule

`default_nettype wire

// File: rtl/bounded_top_k_distinct_set.sv
// ----------------------------------------------------------------------------
// bounded_top_k_distinct_set: keeps the largest distinct values seen
// Sorted chain of CAPACITY cells, head cell holds the minimum.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one signed value per beat.
//   Output channel out_valid/out_ready carries one result beat per input:
//   added, evicted, evicted_value, minimum, minimum_valid, count.
//   cfg_we/cfg_wdata writes the capacity register (reset 64; zero acts as
//   one, values above 64 act as 64). Write it only while the block is idle.
// Timing:
//   Each item goes through accept, a compare cycle in which every cell
//   checks its value against the broadcast value, and an update cycle in
//   which the chain shifts and the result register loads. One item is in
//   the chain at a time, so no new input beat is accepted until the
//   current item has left the update step.
// Reset: synchronous, clears the set, the capacity returns to 64.
// Stall: a held result does not block the next input beat; that item waits
//   in the update step until the result register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_top_k_distinct_set (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [btk_pkg::CAP_W-1:0]         cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [btk_pkg::VALUE_W-1:0] value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   added,
  output logic                                   evicted,
  output logic signed [btk_pkg::VALUE_W-1:0]     evicted_value,
  output logic signed [btk_pkg::VALUE_W-1:0]     minimum,
  output logic                                   minimum_valid,
  output logic [btk_pkg::COUNT_W-1:0]            count
);
  import btk_pkg::*;

  btk_state_t                state;
  btk_state_t                state_next;
  logic signed [VALUE_W-1:0] cur_value;
  logic [COUNT_W-1:0]        held_count;
  logic [COUNT_W-1:0]        held_count_next;
  logic [CAP_W-1:0]          capacity;
  logic [COUNT_W-1:0]        eff_cap;
  btk_ctrl_t                 ctrl;
  btk_op_t                   decided_op;
  logic                      upd_fire;
  logic                      dup;
  logic signed [VALUE_W-1:0] head_next;

  btk_link_t          cell_link [CAPACITY];
  logic [CAPACITY-1:0] eq_vec;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      btk_link_t left_in;
      btk_link_t right_in;
      if (gi == 0) begin : g_head
        assign left_in = '{val: '0, lt: 1'b1, occ: 1'b1};
      end else begin : g_left
        assign left_in = cell_link[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_tail
        assign right_in = '{val: '0, lt: 1'b0, occ: 1'b0};
      end else begin : g_right
        assign right_in = cell_link[gi+1];
      end
      btk_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .ctrl  (ctrl),
        .left  (left_in),
        .right (right_in),
        .link  (cell_link[gi]),
        .eq    (eq_vec[gi])
      );
    end
  endgenerate

  always_comb begin
    if (capacity == '0)                     eff_cap = COUNT_W'(1);
    else if (capacity > CAP_W'(CAPACITY))   eff_cap = COUNT_W'(CAPACITY);
    else                                    eff_cap = COUNT_W'(capacity);
  end

  assign dup = |eq_vec;

  always_comb begin
    if (dup)                        decided_op = OP_HOLD;
    else if (held_count >= eff_cap) decided_op = cell_link[0].lt ? OP_EVICT : OP_HOLD;
    else                            decided_op = OP_INSERT;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_CMP;
      ST_CMP:  state_next = ST_UPD;
      ST_UPD:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready    = 1'b0;
    upd_fire    = 1'b0;
    ctrl.cmp_en = 1'b0;
    ctrl.op     = OP_HOLD;
    ctrl.value  = cur_value;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_CMP:  ctrl.cmp_en = 1'b1;
      ST_UPD: begin
        upd_fire = !out_valid || out_ready;
        if (upd_fire) ctrl.op = decided_op;
      end
      default: in_ready = 1'b0;
    endcase
  end

  // head value after the update, for the minimum field
  always_comb begin
    head_next = cell_link[0].val;
    case (decided_op)
      OP_INSERT: if (!cell_link[0].lt) head_next = cur_value;
      OP_EVICT:  head_next = cell_link[1 % CAPACITY].lt && (CAPACITY > 1) ?
                             cell_link[1 % CAPACITY].val : cur_value;
      default:   head_next = cell_link[0].val;
    endcase
  end

  assign held_count_next = (decided_op == OP_INSERT) ? held_count + COUNT_W'(1) : held_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      held_count <= '0;
      capacity   <= CAP_W'(CAPACITY);
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) capacity <= cfg_wdata;
      if (upd_fire) begin
        held_count <= held_count_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) cur_value <= value;
    if (upd_fire) begin
      added         <= decided_op != OP_HOLD;
      evicted       <= decided_op == OP_EVICT;
      evicted_value <= (decided_op == OP_EVICT) ? cell_link[0].val : '0;
      minimum       <= (held_count_next != '0) ? head_next : '0;
      minimum_valid <= held_count_next != '0;
      count         <= held_count_next;
    end
  end

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for bounded_top_k_distinct_set
// Drives signed values through the valid/ready input, walks the capacity
// register through its extremes, and compares every result beat field by
// field against a sorted-queue prediction of the kept set.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import btk_pkg::*;

  typedef struct {
    logic                      added;
    logic                      evicted;
    logic signed [VALUE_W-1:0] evicted_value;
    logic signed [VALUE_W-1:0] minimum;
    logic                      minimum_valid;
    logic [COUNT_W-1:0]        count;
  } set_outcome_t;

  class topk_set_checker;
    logic signed [VALUE_W-1:0] kept_values[$];   // ascending, entry 0 is the minimum
    set_outcome_t              pending_outcomes[$];
    logic [CAP_W-1:0]          capacity_reg;
    int                        errors;

    function new();
      capacity_reg = 7'd64;
      errors       = 0;
    endfunction

    function int unsigned effective_capacity();
      int unsigned c;
      c = int'(capacity_reg);
      if (c == 0) c = 1;
      if (c > CAPACITY) c = CAPACITY;
      return c;
    endfunction

    function void offer_value(logic signed [VALUE_W-1:0] v);
      set_outcome_t o;
      int           n;
      int           pos;
      o   = '{default: '0};
      n   = kept_values.size();
      pos = 0;
      while (pos < n && kept_values[pos] < v) pos++;
      if (pos < n && kept_values[pos] == v) begin
        // already held: no change
      end else if (n >= effective_capacity()) begin
        // full (or over capacity after a lowered limit): must beat the minimum
        if (pos > 0) begin
          o.evicted       = 1'b1;
          o.evicted_value = kept_values[0];
          o.added         = 1'b1;
          kept_values.insert(pos, v);
          kept_values.delete(0);
        end
      end else begin
        kept_values.insert(pos, v);
        o.added = 1'b1;
      end
      if (kept_values.size() > 0) begin
        o.minimum       = kept_values[0];
        o.minimum_valid = 1'b1;
      end
      o.count = COUNT_W'(kept_values.size());
      pending_outcomes.insert(pending_outcomes.size(), o);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(set_outcome_t got);
      set_outcome_t want;
      if (pending_outcomes.size() == 0) begin
        report("result beat with nothing outstanding");
        return;
      end
      want = pending_outcomes.pop_front();
      if (got.added !== want.added)
        report($sformatf("added %0b, want %0b", got.added, want.added));
      if (got.evicted !== want.evicted)
        report($sformatf("evicted %0b, want %0b", got.evicted, want.evicted));
      if (got.evicted_value !== want.evicted_value)
        report($sformatf("evicted_value %0d, want %0d", got.evicted_value,
                         want.evicted_value));
      if (got.minimum !== want.minimum)
        report($sformatf("minimum %0d, want %0d", got.minimum, want.minimum));
      if (got.minimum_valid !== want.minimum_valid)
        report($sformatf("minimum_valid %0b, want %0b", got.minimum_valid,
                         want.minimum_valid));
      if (got.count !== want.count)
        report($sformatf("count %0d, want %0d", got.count, want.count));
    endtask
  endclass

  localparam int CYCLE_LIMIT     = 900000;
  localparam int ITEMS_PER_PHASE = 135;
  localparam int NUM_PHASES      = 12;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      cfg_we    = 1'b0;
  logic [CAP_W-1:0]          cfg_wdata = '0;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  logic signed [VALUE_W-1:0] value     = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      added;
  logic                      evicted;
  logic signed [VALUE_W-1:0] evicted_value;
  logic signed [VALUE_W-1:0] minimum;
  logic                      minimum_valid;
  logic [COUNT_W-1:0]        count;

  bit              in_calm  = 1'b0;
  bit              out_calm = 1'b0;
  int              cycles   = 0;
  set_outcome_t    seen_beat;
  topk_set_checker chk;

  bounded_top_k_distinct_set dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .value         (value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .added         (added),
    .evicted       (evicted),
    .evicted_value (evicted_value),
    .minimum       (minimum),
    .minimum_valid (minimum_valid),
    .count         (count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // mostly back-to-back or short gaps, now and then a long one
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // biased toward duplicates, the minimum's neighborhood and the range ends
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int                        r;
    int                        n;
    logic signed [VALUE_W-1:0] lo;
    longint                    t;
    longint                    span;
    r = $urandom_range(0, 99);
    n = chk.kept_values.size();
    if (n > 0) lo = chk.kept_values[0];
    if (n > 0 && r < 20) return chk.kept_values[$urandom_range(0, n - 1)];
    if (n > 0 && r < 35) begin
      t = longint'(lo) + longint'($urandom_range(0, 2000)) - 1000;
      if (t < longint'(VAL_MIN)) t = longint'(VAL_MIN);
      if (t > longint'(VAL_MAX)) t = longint'(VAL_MAX);
      return t[VALUE_W-1:0];
    end
    if (n > 0 && r < 50) begin
      span = longint'(VAL_MAX) - longint'(lo);
      t    = longint'(lo) + (longint'($urandom) % (span + 1));
      return t[VALUE_W-1:0];
    end
    if (r < 65) return int'($urandom_range(0, 63)) - 32;
    if (r < 75) begin
      case ($urandom_range(0, 5))
        0:       return VAL_MIN;
        1:       return VAL_MIN + 1;
        2:       return VAL_MAX;
        3:       return VAL_MAX - 1;
        4:       return '0;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  task automatic send_value(input logic signed [VALUE_W-1:0] v);
    int gap;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      value    <= $urandom;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and wait until every outstanding result beat has arrived
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (chk.pending_outcomes.size() != 0);
  endtask

  task automatic write_capacity(input int unsigned c);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= c[CAP_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    chk.capacity_reg = c[CAP_W-1:0];
  endtask

  initial begin : sink_side
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        stall = pick_gap(out_calm);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) chk.offer_value(value);
      if (out_valid && out_ready) begin
        seen_beat = '{added, evicted, evicted_value, minimum, minimum_valid, count};
        chk.check_result(seen_beat);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned phase_caps[NUM_PHASES];
    int unsigned cap;
    phase_caps = '{1, 0, 2, 10, 20, 64, 127, 33, 0, 0, 0, 64};
    chk = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset capacity: empty set, duplicate, both range ends
    send_value(32'sd5);
    send_value(32'sd5);
    send_value(VAL_MIN);
    send_value(VAL_MAX);
    send_value(-32'sd1);

    // capacity below the held count: set stays oversized, each add evicts one
    write_capacity(3);
    send_value(VAL_MIN);
    send_value(32'sd0);
    send_value(-32'sd1);
    send_value(-32'sd2);
    send_value(32'sd1);
    send_value(VAL_MAX);
    send_value(32'sd0);

    // zero acts as one
    write_capacity(0);
    send_value(32'sd2);
    send_value(32'sd0);
    send_value(VAL_MAX - 1);

    // above the cell count saturates
    write_capacity(127);
    send_value(VAL_MIN + 1);
    send_value(32'hAAAA_AAAA);
    send_value(32'h5555_5555);

    for (int p = 0; p < NUM_PHASES; p++) begin
      cap = (p >= 8 && p <= 10) ? $urandom_range(0, 127) : phase_caps[p];
      write_capacity(cap);
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      repeat (ITEMS_PER_PHASE) send_value(pick_value());
    end

    settle();
    repeat (8) @(posedge clk);
    if (chk.errors == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

`default_nettype wire

// File: bounded_top_k_distinct_set.f
rtl/btk_pkg.sv
rtl/btk_cell.sv
rtl/bounded_top_k_distinct_set.sv
dv/tb_top.sv
